/* hw/rtl/lpmr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lpmr_pkg
// Shared types, constants and pointer helpers for the length-prefixed
// message ring.
// ----------------------------------------------------------------------------
package lpmr_pkg;

    // Ring geometry. The ring size is meant to be a multiple of four.
    localparam int BUF_BYTES  = 4096;
    localparam int ADDR_W     = $clog2(BUF_BYTES);
    localparam int PTR_EXT_W  = ADDR_W + 1;
    localparam int HDR_DEPTH  = BUF_BYTES / 4;
    localparam int HDR_AW     = ADDR_W - 2;

    // Field widths of the channels.
    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 12;
    localparam int CNT_W      = 12;

    // Header size and the space a message needs beyond its payload.
    localparam int HDR_BYTES    = 4;
    localparam int SPACE_MARGIN = 8;
    localparam int CMP_W        = ((PTR_EXT_W > LEN_W) ? PTR_EXT_W : LEN_W) + 1;

    localparam logic MODE_PUT = 1'b0;
    localparam logic MODE_GET = 1'b1;

    typedef logic [ADDR_W-1:0] ptr_t;
    typedef logic [LEN_W-1:0]  len_t;
    typedef logic [BYTE_W-1:0] byte_t;

    typedef enum logic [2:0] {
        STAT_GET_BYTE    = 3'd0,
        STAT_GET_EMPTY   = 3'd1,
        STAT_PUT_STORED  = 3'd2,
        STAT_PUT_NOSPACE = 3'd3,
        STAT_PUT_DISCARD = 3'd4
    } status_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // Add a small offset to a ring pointer, wrapping at the ring size.
    function automatic ptr_t ptr_add(ptr_t p, logic [2:0] k);
        logic [PTR_EXT_W-1:0] s;
        s = {1'b0, p} + PTR_EXT_W'(k);
        if (s >= PTR_EXT_W'(BUF_BYTES))
            s = s - PTR_EXT_W'(BUF_BYTES);
        return s[ADDR_W-1:0];
    endfunction

    // Round a pointer up to the next word boundary, wrapping at the ring size.
    function automatic ptr_t ptr_pad4(ptr_t p);
        logic [PTR_EXT_W-1:0] s;
        s = {1'b0, p} + PTR_EXT_W'(3);
        s[1:0] = 2'b00;
        if (s >= PTR_EXT_W'(BUF_BYTES))
            s = s - PTR_EXT_W'(BUF_BYTES);
        return s[ADDR_W-1:0];
    endfunction

    // Committed occupancy between the write and read pointers.
    function automatic ptr_t ring_used(ptr_t wc, ptr_t rc);
        logic [PTR_EXT_W-1:0] s;
        if (wc >= rc)
            s = {1'b0, wc} - {1'b0, rc};
        else
            s = {1'b0, wc} + PTR_EXT_W'(BUF_BYTES) - {1'b0, rc};
        return s[ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/lpmr_req_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lpmr_req_if
// Request channel of the message ring: one put or get beat per word.
// ----------------------------------------------------------------------------
interface lpmr_req_if;
    import lpmr_pkg::*;

    logic  valid;
    logic  ready;
    logic  mode;
    byte_t put_byte;
    len_t  put_len;

    modport source (output valid, output mode, output put_byte, output put_len,
                    input ready);
    modport sink   (input valid, input mode, input put_byte, input put_len,
                    output ready);
endinterface

`default_nettype wire

/* hw/rtl/lpmr_rsp_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lpmr_rsp_if
// Response channel of the message ring: one result word per request.
// ----------------------------------------------------------------------------
interface lpmr_rsp_if;
    import lpmr_pkg::*;

    logic              valid;
    logic              ready;
    status_t           status;
    byte_t             data_byte;
    len_t              msg_len;
    logic              last;
    logic [CNT_W-1:0]  used_bytes;
    logic [CNT_W-1:0]  free_bytes;
    logic              is_empty;
    logic              is_full;

    modport source (output valid, output status, output data_byte, output msg_len,
                    output last, output used_bytes, output free_bytes,
                    output is_empty, output is_full, input ready);
    modport sink   (input valid, input status, input data_byte, input msg_len,
                    input last, input used_bytes, input free_bytes,
                    input is_empty, input is_full, output ready);
endinterface

`default_nettype wire

/* hw/rtl/lpmr_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lpmr_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module lpmr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // Registered read port; data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
            rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* hw/rtl/length_prefixed_message_ring_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// length_prefixed_message_ring_core
// Byte ring that stores whole messages behind a length header and hands
// them back byte by byte, committing each side only at message ends.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake     Payload
//  req      in   valid/ready   mode, put_byte, put_len
//  rsp      out  valid/ready   status, data_byte, msg_len, last,
//                              used_bytes, free_bytes, is_empty, is_full
//
// For each word, the accept cycle of a get issues the reads of the payload
// RAM and the header RAM; the execute state then updates the pointers,
// writes the RAMs and loads the result register.
// A new word is taken as soon as the previous one has left the execute
// cycle, even while its result still waits in the output register.
// The execute cycle waits only while the output register is full and stalled.
// Reset clears all pointers and counters; the RAMs need no clearing pass.
// ----------------------------------------------------------------------------
module length_prefixed_message_ring_core (
    input  wire logic clk,
    input  wire logic rst_n,
    lpmr_req_if.sink  req,
    lpmr_rsp_if.source rsp
);
    import lpmr_pkg::*;

    // Control and pointer state.
    state_t  state_reg,     state_next;
    ptr_t    wc_reg,        wc_next;
    ptr_t    ww_reg,        ww_next;
    len_t    put_rem_reg,   put_rem_next;
    logic    put_disc_reg,  put_disc_next;
    ptr_t    rc_reg,        rc_next;
    ptr_t    rw_reg,        rw_next;
    len_t    get_rem_reg,   get_rem_next;
    len_t    get_len_reg,   get_len_next;
    logic    rsp_valid_reg, rsp_valid_next;

    // Captured request word.
    logic    mode_reg;
    byte_t   byte_reg;
    len_t    len_reg;

    // Result payload.
    status_t           status_reg,   status_next;
    byte_t             data_reg,     data_next;
    len_t              mlen_reg,     mlen_next;
    logic              last_reg,     last_next;
    logic [CNT_W-1:0]  used_reg,     used_next;
    logic [CNT_W-1:0]  free_reg,     free_next;
    logic              empty_reg,    empty_next;
    logic              full_reg,     full_next;

    // RAM ports.
    logic              dat_we, dat_re, hdr_we;
    ptr_t              dat_waddr, dat_raddr;
    byte_t             dat_wdata, dat_rdata;
    logic [HDR_AW-1:0] hdr_waddr, hdr_raddr;
    len_t              hdr_rdata;

    logic accept;
    logic exec_fire;

    // Working values of the execute cycle.
    ptr_t              used_now;
    ptr_t              wp;
    ptr_t              rp;
    len_t              rem_eff;
    logic              no_space;
    logic [CMP_W-1:0]  space_have;
    logic [CMP_W-1:0]  space_need;
    ptr_t              used_after;
    logic [CMP_W-1:0]  free_after;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign exec_fire = (state_reg == ST_EXEC) && (!rsp_valid_reg || rsp.ready);

    // Payload bytes of the ring.
    lpmr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BUF_BYTES)
    ) u_dat_ram (
        .clk   (clk),
        .we    (dat_we),
        .waddr (dat_waddr),
        .wdata (dat_wdata),
        .re    (dat_re),
        .raddr (dat_raddr),
        .rdata (dat_rdata)
    );

    // Message lengths, one per word-aligned header slot.
    lpmr_ram #(
        .WIDTH (LEN_W),
        .DEPTH (HDR_DEPTH)
    ) u_hdr_ram (
        .clk   (clk),
        .we    (hdr_we),
        .waddr (hdr_waddr),
        .wdata (len_reg),
        .re    (dat_re),
        .raddr (hdr_raddr),
        .rdata (hdr_rdata)
    );

    // Reads are issued at accept: the header of the oldest message and the
    // byte the get word will return.
    assign dat_re    = accept && (req.mode == MODE_GET);
    assign hdr_raddr = rc_reg[ADDR_W-1:2];
    assign dat_raddr = (get_rem_reg == '0) ? ptr_add(rc_reg, 3'(HDR_BYTES)) : rw_reg;

    // Execute: pointer update, RAM writes and result.
    always_comb
    begin
        state_next     = state_reg;
        wc_next        = wc_reg;
        ww_next        = ww_reg;
        put_rem_next   = put_rem_reg;
        put_disc_next  = put_disc_reg;
        rc_next        = rc_reg;
        rw_next        = rw_reg;
        get_rem_next   = get_rem_reg;
        get_len_next   = get_len_reg;
        rsp_valid_next = rsp_valid_reg;

        status_next = status_reg;
        data_next   = data_reg;
        mlen_next   = mlen_reg;
        last_next   = last_reg;
        used_next   = used_reg;
        free_next   = free_reg;
        empty_next  = empty_reg;
        full_next   = full_reg;

        dat_we    = 1'b0;
        dat_waddr = ww_reg;
        dat_wdata = byte_reg;
        hdr_we    = 1'b0;
        hdr_waddr = wc_reg[ADDR_W-1:2];

        used_now   = ring_used(wc_reg, rc_reg);
        space_have = CMP_W'(BUF_BYTES) - CMP_W'(used_now);
        space_need = CMP_W'(len_reg) + CMP_W'(SPACE_MARGIN);
        no_space   = (space_have < space_need);
        wp         = ww_reg;
        rp         = rw_reg;
        rem_eff    = put_rem_reg;
        used_after = used_now;
        free_after = '0;

        if (rsp_valid_reg && rsp.ready)
            rsp_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_EXEC;
            end

            ST_EXEC:
            begin
                if (exec_fire)
                begin
                    state_next     = ST_IDLE;
                    rsp_valid_next = 1'b1;
                    data_next      = '0;
                    mlen_next      = '0;
                    last_next      = 1'b0;

                    if (mode_reg == MODE_PUT)
                    begin
                        // Put beat.
                        if (put_rem_reg == '0 && len_reg == '0)
                        begin
                            status_next = STAT_PUT_DISCARD;
                            last_next   = 1'b1;
                        end
                        else if (put_rem_reg == '0 && no_space)
                        begin
                            // Rejected message: drop this and all later beats.
                            status_next   = STAT_PUT_NOSPACE;
                            put_rem_next  = len_reg - LEN_W'(1);
                            put_disc_next = (len_reg != LEN_W'(1));
                            last_next     = (len_reg == LEN_W'(1));
                        end
                        else if (put_rem_reg != '0 && put_disc_reg)
                        begin
                            status_next  = STAT_PUT_DISCARD;
                            put_rem_next = put_rem_reg - LEN_W'(1);
                            if (put_rem_reg == LEN_W'(1))
                            begin
                                put_disc_next = 1'b0;
                                last_next     = 1'b1;
                            end
                        end
                        else
                        begin
                            // Store the byte; the first beat also writes the header.
                            if (put_rem_reg == '0)
                            begin
                                hdr_we        = 1'b1;
                                wp            = ptr_add(wc_reg, 3'(HDR_BYTES));
                                rem_eff       = len_reg;
                                put_disc_next = 1'b0;
                            end
                            dat_we       = 1'b1;
                            dat_waddr    = wp;
                            ww_next      = ptr_add(wp, 3'd1);
                            put_rem_next = rem_eff - LEN_W'(1);
                            status_next  = STAT_PUT_STORED;
                            if (rem_eff == LEN_W'(1))
                            begin
                                wc_next   = ptr_pad4(ptr_add(wp, 3'd1));
                                last_next = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        // Get beat.
                        if (get_rem_reg == '0 && rc_reg == wc_reg)
                        begin
                            status_next = STAT_GET_EMPTY;
                        end
                        else if (get_rem_reg == '0 && hdr_rdata == '0)
                        begin
                            // Corrupt header: skip it.
                            rw_next     = ptr_add(rc_reg, 3'(HDR_BYTES));
                            rc_next     = ptr_pad4(ptr_add(rc_reg, 3'(HDR_BYTES)));
                            status_next = STAT_GET_EMPTY;
                        end
                        else
                        begin
                            if (get_rem_reg == '0)
                            begin
                                rp           = ptr_add(rc_reg, 3'(HDR_BYTES));
                                get_len_next = hdr_rdata;
                                mlen_next    = hdr_rdata;
                                get_rem_next = hdr_rdata - LEN_W'(1);
                                last_next    = (hdr_rdata == LEN_W'(1));
                            end
                            else
                            begin
                                mlen_next    = get_len_reg;
                                get_rem_next = get_rem_reg - LEN_W'(1);
                                last_next    = (get_rem_reg == LEN_W'(1));
                            end
                            data_next   = dat_rdata;
                            rw_next     = ptr_add(rp, 3'd1);
                            status_next = STAT_GET_BYTE;
                            if (last_next)
                                rc_next = ptr_pad4(ptr_add(rp, 3'd1));
                        end
                    end

                    // Occupancy after this beat's commits.
                    used_after = ring_used(wc_next, rc_next);
                    free_after = CMP_W'(BUF_BYTES - HDR_BYTES) - CMP_W'(used_after);
                    used_next  = CNT_W'(used_after);
                    free_next  = free_after[CNT_W-1:0];
                    empty_next = (wc_next == rc_next);
                    full_next  = (ptr_add(wc_next, 3'(HDR_BYTES)) == rc_next);
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wc_reg        <= '0;
            ww_reg        <= '0;
            put_rem_reg   <= '0;
            put_disc_reg  <= 1'b0;
            rc_reg        <= '0;
            rw_reg        <= '0;
            get_rem_reg   <= '0;
            get_len_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wc_reg        <= wc_next;
            ww_reg        <= ww_next;
            put_rem_reg   <= put_rem_next;
            put_disc_reg  <= put_disc_next;
            rc_reg        <= rc_next;
            rw_reg        <= rw_next;
            get_rem_reg   <= get_rem_next;
            get_len_reg   <= get_len_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Captured request and result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= req.mode;
            byte_reg <= req.put_byte;
            len_reg  <= req.put_len;
        end
        status_reg <= status_next;
        data_reg   <= data_next;
        mlen_reg   <= mlen_next;
        last_reg   <= last_next;
        used_reg   <= used_next;
        free_reg   <= free_next;
        empty_reg  <= empty_next;
        full_reg   <= full_next;
    end

    // Response channel.
    assign rsp.valid      = rsp_valid_reg;
    assign rsp.status     = status_reg;
    assign rsp.data_byte  = data_reg;
    assign rsp.msg_len    = mlen_reg;
    assign rsp.last       = last_reg;
    assign rsp.used_bytes = used_reg;
    assign rsp.free_bytes = free_reg;
    assign rsp.is_empty   = empty_reg;
    assign rsp.is_full    = full_reg;

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the length-prefixed message ring core word by word. A table of
// directed rows covers the empty ring, zero-length and rejected messages,
// a full ring, pointer wrap and interleaved traffic. Random traffic then
// runs near the full mark, around a long stall of the result side. Every
// result word is compared against a behavioral copy of the ring kept
// inside this file, or for the first word of a typed row against listed values.
// ----------------------------------------------------------------------------
module testbench;
    import lpmr_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 6_000_000;
    localparam int unsigned SETTLE_CYCLES = 20;
    localparam int unsigned PLAN_ROWS     = 17;

    // One result word, laid out as the response channel carries it.
    typedef struct packed {
        status_t          status;
        byte_t            data_byte;
        len_t             msg_len;
        logic             last;
        logic [CNT_W-1:0] used_bytes;
        logic [CNT_W-1:0] free_bytes;
        logic             is_empty;
        logic             is_full;
    } ring_word_t;

    typedef enum {
        ROW_GET,
        ROW_PUT,
        ROW_WEAVE,
        ROW_DRAIN,
        ROW_FILL
    } row_kind_t;

    typedef enum {
        FILL_RAND,
        FILL_ZERO,
        FILL_ONES
    } fill_t;

    // A directed row: a run of get words, one whole message of put words,
    // a drain of the ring, or a run of one-byte messages.
    typedef struct {
        row_kind_t   kind;
        int unsigned beats;
        fill_t       fill;
        bit          typed;
        ring_word_t  first;
    } plan_row_t;

    logic clk;
    logic rst_n;

    lpmr_req_if req();
    lpmr_rsp_if rsp();

    length_prefixed_message_ring_core i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    // Behavioral copy of the ring contents and pointers.
    byte_t       ring_mem [BUF_BYTES];
    int unsigned wr_commit    = 0;
    int unsigned wr_cursor    = 0;
    int unsigned rd_commit    = 0;
    int unsigned rd_cursor    = 0;
    int unsigned put_left     = 0;
    int unsigned get_left     = 0;
    len_t        get_len      = '0;
    bit          put_dropping = 1'b0;

    ring_word_t  pending_words [$];
    plan_row_t   plan [PLAN_ROWS];

    int unsigned error_count   = 0;
    int unsigned beats_sent    = 0;
    int unsigned words_checked = 0;
    int unsigned random_beats  = 0;
    int unsigned gen_put_left  = 0;
    int unsigned hold_len      = 0;
    int unsigned full_seen     = 0;
    int unsigned cycle_count   = 0;
    int unsigned status_seen [5];
    bit          tx_quiet      = 1'b0;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Free-running cycle counter for the watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Watchdog: a hung handshake ends the run here.
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t: timeout after %0d cycles, %0d words outstanding",
                 $time, cycle_count, pending_words.size());
        $display("CHECKS FAILED");
        $finish;
    end

    // Committed occupancy of the ring.
    function automatic int unsigned ring_fill_level();
        return (BUF_BYTES - rd_commit + wr_commit) % BUF_BYTES;
    endfunction

    // Round a pointer up to a 4-byte boundary and wrap it.
    function automatic int unsigned ring_align(int unsigned p);
        return ((p + 3) & ~32'd3) % BUF_BYTES;
    endfunction

    // Result word with the counters derived from the occupancy.
    function automatic ring_word_t make_word(status_t s, byte_t d, len_t l, logic fin,
                                             int unsigned used);
        ring_word_t w;
        w.status     = s;
        w.data_byte  = d;
        w.msg_len    = l;
        w.last       = fin;
        w.used_bytes = CNT_W'(used);
        w.free_bytes = CNT_W'(BUF_BYTES - 4 - used);
        w.is_empty   = (used == 0);
        w.is_full    = (used == BUF_BYTES - 4);
        return w;
    endfunction

    // Apply one request word to the ring copy and return its result word.
    function automatic ring_word_t ring_advance(logic m, byte_t b, len_t l);
        ring_word_t  w;
        len_t        hdr;
        bit          done;
        int unsigned used;
        w = '0;
        w.status = STAT_GET_EMPTY;
        done = 1'b0;
        if (m == MODE_PUT)
        begin
            w.status = STAT_PUT_DISCARD;
            if (put_left == 0)
            begin
                if (l == 0)
                begin
                    // A zero-length message is complete and dropped at once.
                    w.last = 1'b1;
                    done = 1'b1;
                end
                else if (BUF_BYTES - ring_fill_level() < l + 8)
                begin
                    // Not enough room: swallow the whole message.
                    put_dropping = 1'b1;
                    put_left = l - 1;
                    w.status = STAT_PUT_NOSPACE;
                    if (put_left == 0)
                    begin
                        put_dropping = 1'b0;
                        w.last = 1'b1;
                    end
                    done = 1'b1;
                end
                else
                begin
                    // Accepted: lay down the header at the committed pointer.
                    put_dropping = 1'b0;
                    ring_mem[wr_commit] = l[7:0];
                    ring_mem[(wr_commit + 1) % BUF_BYTES] = byte_t'(l[11:8]);
                    ring_mem[(wr_commit + 2) % BUF_BYTES] = '0;
                    ring_mem[(wr_commit + 3) % BUF_BYTES] = '0;
                    wr_cursor = (wr_commit + 4) % BUF_BYTES;
                    put_left = l;
                end
            end
            if (!done && put_dropping)
            begin
                put_left--;
                if (put_left == 0)
                begin
                    put_dropping = 1'b0;
                    w.last = 1'b1;
                end
            end
            else if (!done)
            begin
                ring_mem[wr_cursor] = b;
                wr_cursor = (wr_cursor + 1) % BUF_BYTES;
                put_left--;
                w.status = STAT_PUT_STORED;
                if (put_left == 0)
                begin
                    wr_commit = ring_align(wr_cursor);
                    w.last = 1'b1;
                end
            end
        end
        else
        begin
            if (get_left == 0)
            begin
                if (rd_commit == wr_commit)
                begin
                    done = 1'b1;
                end
                else
                begin
                    hdr = len_t'({ring_mem[(rd_commit + 1) % BUF_BYTES], ring_mem[rd_commit]});
                    rd_cursor = (rd_commit + 4) % BUF_BYTES;
                    if (hdr == 0)
                    begin
                        // A zero header only skips past itself.
                        rd_commit = ring_align(rd_cursor);
                        done = 1'b1;
                    end
                    else
                    begin
                        get_len = hdr;
                        get_left = hdr;
                    end
                end
            end
            if (!done)
            begin
                w.data_byte = ring_mem[rd_cursor];
                w.msg_len = get_len;
                rd_cursor = (rd_cursor + 1) % BUF_BYTES;
                get_left--;
                w.status = STAT_GET_BYTE;
                if (get_left == 0)
                begin
                    rd_commit = ring_align(rd_cursor);
                    w.last = 1'b1;
                end
            end
        end
        used = ring_fill_level();
        w.used_bytes = CNT_W'(used);
        w.free_bytes = CNT_W'(BUF_BYTES - 4 - used);
        w.is_empty = (wr_commit == rd_commit);
        w.is_full = (((wr_commit + 4) % BUF_BYTES) == rd_commit);
        return w;
    endfunction

    // Idle length: mostly none, some short, a few long.
    function automatic int unsigned pick_idle();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // Message length: mostly short, a few zero, rarely a few hundred.
    function automatic len_t pick_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 6)
            return '0;
        else if (r < 80)
            return len_t'($urandom_range(1, 24));
        else if (r < 96)
            return len_t'($urandom_range(25, 120));
        else
            return len_t'($urandom_range(200, 600));
    endfunction

    function automatic byte_t fill_byte(fill_t f);
        case (f)
            FILL_ZERO: return 8'h00;
            FILL_ONES: return 8'hFF;
            default:   return byte_t'($urandom);
        endcase
    endfunction

    // Offer one request word, wait for it to be taken, and queue its result.
    task automatic send_beat(input logic m, input byte_t b, input len_t l,
                             input bit typed, input ring_word_t typed_word);
        int unsigned idle;
        ring_word_t  predicted;
        idle = tx_quiet ? 0 : pick_idle();
        if (idle > 0)
        begin
            @(negedge clk);
            req.valid    <= 1'b0;
            req.mode     <= logic'($urandom);
            req.put_byte <= byte_t'($urandom);
            req.put_len  <= len_t'($urandom);
            repeat (idle - 1) @(negedge clk);
        end
        @(negedge clk);
        req.valid    <= 1'b1;
        req.mode     <= m;
        req.put_byte <= b;
        req.put_len  <= l;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        predicted = ring_advance(m, b, l);
        pending_words.push_back(typed ? typed_word : predicted);
        beats_sent++;
    endtask

    task automatic get_beat();
        send_beat(MODE_GET, byte_t'($urandom), len_t'($urandom), 1'b0, '0);
    endtask

    // Next put word of a well-formed message; a new message starts when the
    // previous one is complete, and later words carry a junk length.
    task automatic next_put_beat();
        len_t l;
        if (gen_put_left == 0)
        begin
            l = pick_length();
            gen_put_left = (l == 0) ? 0 : l - 1;
        end
        else
        begin
            gen_put_left--;
            l = len_t'($urandom);
        end
        send_beat(MODE_PUT, byte_t'($urandom), l, 1'b0, '0);
    endtask

    // Stop offering words until every outstanding result has come back.
    task automatic wait_drain();
        @(negedge clk);
        req.valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
    endtask

    // Finish the open message, then read the ring until it is empty.
    task automatic drain_ring();
        while (gen_put_left > 0)
            next_put_beat();
        while (get_left != 0 || rd_commit != wr_commit)
            get_beat();
    endtask

    task automatic run_row(plan_row_t row);
        int unsigned n;
        n = (row.beats == 0) ? 1 : row.beats;
        if (row.kind == ROW_DRAIN)
        begin
            drain_ring();
        end
        else
        begin
            for (int unsigned k = 0; k < n; k++)
            begin
                if (row.kind == ROW_GET)
                begin
                    send_beat(MODE_GET, byte_t'($urandom), len_t'($urandom),
                              row.typed && k == 0, row.first);
                end
                else if (row.kind == ROW_FILL)
                begin
                    // Each word is a whole one-byte message.
                    send_beat(MODE_PUT, fill_byte(row.fill), len_t'(1),
                              row.typed && k == 0, row.first);
                end
                else
                begin
                    send_beat(MODE_PUT, fill_byte(row.fill),
                              (k == 0) ? len_t'(row.beats) : len_t'($urandom),
                              row.typed && k == 0, row.first);
                    if (row.kind == ROW_WEAVE)
                        get_beat();
                end
            end
        end
    endtask

    // Random traffic in chunks with a changing put/get mix.
    task automatic run_random(int unsigned count, bit near_full);
        int unsigned put_pct;
        int unsigned chunk_left;
        put_pct = 50;
        chunk_left = 0;
        repeat (count)
        begin
            if (chunk_left == 0)
            begin
                chunk_left = $urandom_range(30, 60);
                tx_quiet = ($urandom_range(0, 3) == 0);
                case ($urandom_range(0, 3))
                    0:       put_pct = 25;
                    1:       put_pct = 50;
                    2:       put_pct = 75;
                    default: put_pct = 90;
                endcase
                if (near_full)
                    put_pct = 60;
            end
            chunk_left--;
            if ($urandom_range(0, 99) < put_pct)
                next_put_beat();
            else
                get_beat();
            random_beats++;
        end
        tx_quiet = 1'b0;
    endtask

    task automatic compare_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Compare one accepted result word with the oldest expectation.
    task automatic check_word();
        ring_word_t want;
        ring_word_t got;
        got.status     = rsp.status;
        got.data_byte  = rsp.data_byte;
        got.msg_len    = rsp.msg_len;
        got.last       = rsp.last;
        got.used_bytes = rsp.used_bytes;
        got.free_bytes = rsp.free_bytes;
        got.is_empty   = rsp.is_empty;
        got.is_full    = rsp.is_full;
        words_checked++;
        if (got.status <= STAT_PUT_DISCARD)
            status_seen[got.status]++;
        if (got.is_full)
            full_seen++;
        if (pending_words.size() == 0)
        begin
            error_count++;
            $display("%0t: result word with no request outstanding, status %0d",
                     $time, got.status);
        end
        else
        begin
            want = pending_words.pop_front();
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("data_byte", 32'(want.data_byte), 32'(got.data_byte));
            compare_field("msg_len", 32'(want.msg_len), 32'(got.msg_len));
            compare_field("last", 32'(want.last), 32'(got.last));
            compare_field("used_bytes", 32'(want.used_bytes), 32'(got.used_bytes));
            compare_field("free_bytes", 32'(want.free_bytes), 32'(got.free_bytes));
            compare_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
            compare_field("is_full", 32'(want.is_full), 32'(got.is_full));
        end
    endtask

    // Result monitor.
    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
            check_word();
    end

    // Result receiver: random stalls, quiet stretches, and a requested hold.
    initial
    begin
        int unsigned stall_left;
        int unsigned quiet_left;
        int unsigned r;
        stall_left = 0;
        quiet_left = 0;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_len > 0)
            begin
                stall_left = hold_len;
                hold_len = 0;
            end
            if (stall_left > 0)
            begin
                rsp.ready <= 1'b0;
                stall_left--;
            end
            else if (quiet_left > 0)
            begin
                rsp.ready <= 1'b1;
                quiet_left--;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 3)
                begin
                    quiet_left = $urandom_range(40, 150);
                    rsp.ready <= 1'b1;
                end
                else if (r < 78)
                begin
                    rsp.ready <= 1'b1;
                end
                else
                begin
                    stall_left = (r < 96) ? $urandom_range(0, 2) : $urandom_range(7, 29);
                    rsp.ready <= 1'b0;
                end
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin
        rst_n        = 1'b0;
        req.valid    = 1'b0;
        req.mode     = MODE_PUT;
        req.put_byte = '0;
        req.put_len  = '0;

        // Typed rows check only their first word against the listed values.
        // The drain row starts the fill from an empty ring, so the fill of
        // one-byte messages plus one five-byte message ends exactly full.
        plan = '{
            '{ROW_GET,   1,    FILL_RAND, 1'b1,
              make_word(STAT_GET_EMPTY, 8'h00, 12'd0, 1'b0, 0)},
            '{ROW_PUT,   0,    FILL_RAND, 1'b1,
              make_word(STAT_PUT_DISCARD, 8'h00, 12'd0, 1'b1, 0)},
            '{ROW_PUT,   1,    FILL_ONES, 1'b1,
              make_word(STAT_PUT_STORED, 8'h00, 12'd0, 1'b1, 8)},
            '{ROW_GET,   1,    FILL_RAND, 1'b1,
              make_word(STAT_GET_BYTE, 8'hFF, 12'd1, 1'b1, 0)},
            '{ROW_GET,   1,    FILL_RAND, 1'b1,
              make_word(STAT_GET_EMPTY, 8'h00, 12'd0, 1'b0, 0)},
            '{ROW_PUT,   2,    FILL_ZERO, 1'b0, '0},
            '{ROW_PUT,   3,    FILL_ONES, 1'b0, '0},
            '{ROW_WEAVE, 5,    FILL_RAND, 1'b0, '0},
            '{ROW_GET,   6,    FILL_RAND, 1'b0, '0},
            '{ROW_PUT,   12,   FILL_RAND, 1'b0, '0},
            '{ROW_GET,   20,   FILL_RAND, 1'b0, '0},
            '{ROW_DRAIN, 0,    FILL_RAND, 1'b0, '0},
            '{ROW_FILL,  510,  FILL_ONES, 1'b0, '0},
            '{ROW_PUT,   5,    FILL_RAND, 1'b1,
              make_word(STAT_PUT_STORED, 8'h00, 12'd0, 1'b0, BUF_BYTES - 16)},
            '{ROW_PUT,   1,    FILL_RAND, 1'b1,
              make_word(STAT_PUT_NOSPACE, 8'h00, 12'd0, 1'b1, BUF_BYTES - 4)},
            '{ROW_PUT,   0,    FILL_RAND, 1'b1,
              make_word(STAT_PUT_DISCARD, 8'h00, 12'd0, 1'b1, BUF_BYTES - 4)},
            '{ROW_GET,   1,    FILL_RAND, 1'b1,
              make_word(STAT_GET_BYTE, 8'hFF, 12'd1, 1'b1, BUF_BYTES - 12)}
        };

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
            run_row(plan[i]);

        // The last rows leave the ring close to full: traffic at the edge.
        run_random(20, 1'b1);

        // Hold the result side off while words keep coming, then pause.
        hold_len = 250;
        tx_quiet = 1'b1;
        repeat (40)
        begin
            if ($urandom_range(0, 1) == 0)
                next_put_beat();
            else
                get_beat();
            random_beats++;
        end
        tx_quiet = 1'b0;
        wait_drain();

        run_random(20, 1'b0);
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        error_count += pending_words.size();

        $display("Run covered %0d request words (%0d random) and %0d result words.",
                 beats_sent, random_beats, words_checked);
        $display("Status mix: byte %0d, empty %0d, stored %0d, no space %0d,",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        $display("dropped %0d; full ring seen in %0d result words.",
                 status_seen[4], full_seen);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
